FILE: src/dtn_pkg.sv
package dtn_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MIN_DIM       = 3;
  localparam int NUM_PASSES    = 4;
  localparam int CFG_W         = 11;
  localparam int CNT_W         = 21;
  localparam int THR_W         = 23;
  localparam int PIX_W         = 8;
  localparam int WIN_W         = 9;
  localparam int LB_W          = 2 * NUM_PASSES;
  localparam int DATA_W        = 32;
  localparam int PADDR_W       = 3;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;

  typedef enum logic [1:0] {
    DIR_EAST,
    DIR_WEST,
    DIR_SOUTH,
    DIR_NORTH
  } dir_t;

  typedef enum logic {
    REQ_PIXEL,
    REQ_DRAIN
  } req_t;

  typedef enum logic {
    REG_WIDTH,
    REG_HEIGHT
  } reg_idx_t;

  // Window layout: bits 0..2 top row, 3..5 middle, 6..8 bottom; in each row
  // bit 0 is the right column and bit 2 the left column.
  function automatic logic pass_decide(logic [WIN_W-1:0] win, dir_t dir);
    logic a, b, c, d, e, f, g, h, i;
    logic test, hit;
    a = win[2];
    b = win[1];
    c = win[0];
    d = win[5];
    e = win[4];
    f = win[3];
    g = win[8];
    h = win[7];
    i = win[6];
    case (dir)
      DIR_EAST:  test = !f;
      DIR_WEST:  test = !d;
      DIR_SOUTH: test = !h;
      default:   test = !b;
    endcase
    hit = (a && c && b) || (g && i && h) || (a && d && g) || (c && f && i) ||
          (a && b && d && !c && !g && !h && !f && !i) ||
          (g && h && d && !a && !i && !b && !f && !c) ||
          (f && i && h && !c && !g && !b && !d && !a) ||
          (b && c && f && !a && !i && !h && !d && !g);
    return e && !(test && hit);
  endfunction

endpackage

FILE: src/directional_edge_thinning.sv
// Directional edge thinning over a raster stream of edge pixels.
// Input channel (in_valid/in_ready): one transaction per pixel, with
// req_type selecting a frame pixel or a drain item; pixel_in counts as set
// when nonzero. Output channel (out_valid/out_ready): thinned pixel and a
// flag on the final pixel of the frame. Four 3x3 thinning passes (east,
// west, south, north) run in cascade, each delaying the stream by W+1
// items, so the output for pixel j is produced by input item j+4*(W+1);
// drain items push the tail of a frame out.
// Throughput is one transaction per clock unless the output stalls. An
// accepted item reads the line buffer at its column into the evaluation
// stage, which evaluates all four passes, writes the line buffer back and
// registers the result. A stalled output holds a result item, which stops
// input acceptance; the output register keeps its transaction until taken.
// Reset restores 640x480 and starts a new frame; the block takes input once
// init_done is set after reset. The line buffer is not cleared: entries
// are always rewritten within a frame before any result depends on them.
// Writing image_width or image_height through the APB port restarts the
// frame; writes are expected only while the block is idle.
module directional_edge_thinning #(
  parameter int MAX_WIDTH = dtn_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [dtn_pkg::PIX_W-1:0]     pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          pixel_out,
  output logic                          last_pixel,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtn_pkg::PADDR_W-1:0]   paddr,
  input  logic [dtn_pkg::DATA_W-1:0]    pwdata,
  output logic [dtn_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import dtn_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Configuration registers.
  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic             cfg_wr;
  reg_idx_t         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (cfg_sel == REG_HEIGHT) ? DATA_W'(cfg_height) : DATA_W'(cfg_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_W'(RESET_WIDTH);
      cfg_height <= CFG_W'(RESET_HEIGHT);
    end else if (cfg_wr) begin
      if (cfg_sel == REG_WIDTH) begin
        cfg_width <= pwdata[CFG_W-1:0];
      end else begin
        cfg_height <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Register values are saturated to the supported frame size.
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;

  always_comb begin
    w_eff = cfg_width;
    if (cfg_width < CFG_W'(MIN_DIM)) begin
      w_eff = CFG_W'(MIN_DIM);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end
    h_eff = cfg_height;
    if (cfg_height < CFG_W'(MIN_DIM)) begin
      h_eff = CFG_W'(MIN_DIM);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end
  end

  // Frame thresholds in item-count terms, recomputed every cycle from the
  // registers. Pass k is live for counts in [thr_lo[k], thr_hi[k]); a result
  // leaves for counts in [res_lo, res_hi), the last one at last_n.
  logic [THR_W-1:0] w_ext;
  logic [THR_W-1:0] d_ext;
  logic [THR_W-1:0] prod;
  logic [THR_W-1:0] total;
  logic [THR_W-1:0] res_lo;
  logic [THR_W-1:0] res_hi;
  logic [THR_W-1:0] last_n;
  logic [THR_W-1:0] thr_lo [NUM_PASSES];
  logic [THR_W-1:0] thr_hi [NUM_PASSES];
  logic             init_done;

  assign w_ext = THR_W'(w_eff);
  assign d_ext = w_ext + THR_W'(1);
  assign prod  = THR_W'(w_eff) * THR_W'(h_eff);

  always_ff @(posedge clk) begin
    total  <= prod;
    res_lo <= d_ext << 2;
    res_hi <= prod + (d_ext << 2);
    last_n <= prod + (d_ext << 2) - THR_W'(1);
    for (int k = 0; k < NUM_PASSES; k++) begin
      thr_lo[k] <= THR_W'(k + 2) * d_ext;
      thr_hi[k] <= prod - w_ext - THR_W'(2) + THR_W'(k + 1) * d_ext;
    end
  end

  // The thresholds are registered from the configuration, so input waits for init_done.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_done <= 1'b0;
    end else begin
      init_done <= 1'b1;
    end
  end

  // Item counter and column (line buffer address) of the next item.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [AW-1:0]    col;
  logic [AW-1:0]    col_next;
  logic             accept;
  logic             x0;

  assign accept = in_valid && in_ready;

  always_comb begin
    if (THR_W'(count) == last_n) begin
      count_next = '0;
    end else begin
      count_next = count + CNT_W'(1);
    end
    if (count_next == '0) begin
      col_next = '0;
    end else if (THR_W'(col) + THR_W'(1) == w_ext) begin
      col_next = '0;
    end else begin
      col_next = col + AW'(1);
    end
  end

  // Drain items and pixels past the end of the frame enter as zero.
  assign x0 = (req_type == REQ_PIXEL) && (pixel_in != '0) && (THR_W'(count) < total);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      col   <= '0;
    end else if (cfg_wr) begin
      count <= '0;
      col   <= '0;
    end else if (accept) begin
      count <= count_next;
      col   <= col_next;
    end
  end

  // Evaluation stage: holds the item whose line buffer read is in flight.
  logic             s1_valid;
  logic [CNT_W-1:0] s1_n;
  logic [AW-1:0]    s1_col;
  logic             s1_x0;
  logic             s1_fire;
  logic             s1_res;
  logic             s1_last;
  logic [THR_W-1:0] s1_n_ext;

  logic [LB_W-1:0]  rd_data;
  logic [LB_W-1:0]  wr_data;
  logic [LB_W-1:0]  lb;
  logic             fwd_hit;
  logic [LB_W-1:0]  fwd_data;

  logic [NUM_PASSES:0]   xchain;
  logic [NUM_PASSES-1:0] active;

  assign s1_n_ext = THR_W'(s1_n);
  assign s1_res   = (s1_n_ext >= res_lo) && (s1_n_ext < res_hi);
  assign s1_last  = (s1_n_ext == last_n);
  assign s1_fire  = s1_valid && (!s1_res || !out_valid || out_ready);
  assign in_ready = init_done && (!s1_valid || s1_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // A frame wrap can put the same column on two neighboring items; the
  // write-back of the older one is then forwarded around the memory.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_n     <= count;
      s1_col   <= col;
      s1_x0    <= x0;
      fwd_hit  <= s1_fire && (s1_col == col);
      fwd_data <= wr_data;
    end
  end

  assign lb = fwd_hit ? fwd_data : rd_data;

  dtn_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  // The four passes in cascade; each one's output is the next one's input.
  assign xchain[0] = s1_x0;

  for (genvar g = 0; g < NUM_PASSES; g++) begin : g_pass
    assign active[g] = (s1_n_ext >= thr_lo[g]) && (s1_n_ext < thr_hi[g]);
    // Upper line takes the old lower-line bit, lower line the pass input.
    assign wr_data[g]              = lb[NUM_PASSES + g];
    assign wr_data[NUM_PASSES + g] = xchain[g];

    dtn_pass #(
      .DIR (dir_t'(g))
    ) u_pass (
      .clk    (clk),
      .rst    (rst),
      .en     (s1_fire),
      .top_in (lb[g]),
      .mid_in (lb[NUM_PASSES + g]),
      .x_in   (xchain[g]),
      .active (active[g]),
      .x_out  (xchain[g + 1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_res) begin
      pixel_out  <= xchain[NUM_PASSES];
      last_pixel <= s1_last;
    end
  end

endmodule

FILE: src/dtn_linebuf.sv
module dtn_linebuf #(
  parameter int DEPTH = dtn_pkg::MAX_WIDTH_DEF,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [dtn_pkg::LB_W-1:0]  rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [dtn_pkg::LB_W-1:0]  wr_data
);
  import dtn_pkg::*;

  // Low nibble holds the upper row line, high nibble the lower row line,
  // one bit per pass in each.
  logic [LB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/dtn_pass.sv
module dtn_pass #(
  parameter dtn_pkg::dir_t DIR = dtn_pkg::DIR_EAST
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic top_in,
  input  logic mid_in,
  input  logic x_in,
  input  logic active,
  output logic x_out
);
  import dtn_pkg::*;

  logic [WIN_W-1:0] win;
  logic [WIN_W-1:0] win_next;

  // Each row of the window shifts left by one column and takes its new
  // right column from the line buffers or from the incoming pixel.
  assign win_next = {win[7:6], x_in, win[4:3], mid_in, win[1:0], top_in};
  assign x_out    = active && pass_decide(win_next, DIR);

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (en) begin
      win <= win_next;
    end
  end

endmodule
